// ===== sv/gmv_pkg.sv =====
`default_nettype none
package gmv_pkg;

	localparam int WORD_W      = 64;
	localparam int IDX_W       = 6;
	localparam int LEN_W       = 7;
	localparam int MAX_WORDS   = 64;
	localparam int STORE_DEPTH = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// row length limit: the smaller of the word limit and the store depth
	localparam int LEN_LIMIT = (MAX_WORDS < STORE_DEPTH) ? MAX_WORDS : STORE_DEPTH;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ROW  = 1'b1;

	// one classified word on its way from front to back
	typedef struct packed {
		logic              is_row;
		logic              is_last;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] data;
	} gmv_entry_t;

endpackage
`default_nettype wire

// ===== sv/gmv_front.sv =====
`default_nettype none
module gmv_front (
	input  wire logic                     item_valid,
	input  wire logic                     opcode,
	input  wire logic [gmv_pkg::IDX_W-1:0]  word_index,
	input  wire logic [gmv_pkg::WORD_W-1:0] word_data,
	input  wire logic [gmv_pkg::LEN_W-1:0]  words_per_row,
	input  wire logic                     queue_full,
	output logic                          item_stall,
	output logic                          push,
	output gmv_pkg::gmv_entry_t           entry
);
	import gmv_pkg::*;

	logic [LEN_W-1:0] row_len;
	logic [LEN_W-1:0] idx_ext;
	logic             keep;

	// clamp the configured length into 1 .. limit
	always_comb begin
		if (words_per_row == '0) begin
			row_len = LEN_W'(1);
		end else if (words_per_row > LEN_W'(LEN_LIMIT)) begin
			row_len = LEN_W'(LEN_LIMIT);
		end else begin
			row_len = words_per_row;
		end
	end

	assign idx_ext = {{(LEN_W-IDX_W){1'b0}}, word_index};

	// loads beyond the store and row words beyond the row are dropped here
	always_comb begin
		if (opcode == OP_ROW) begin
			keep = (idx_ext < row_len);
		end else begin
			keep = (idx_ext < LEN_W'(LEN_LIMIT));
		end
	end

	assign item_stall    = queue_full;
	assign push          = item_valid && !queue_full && keep;
	assign entry.is_row  = (opcode == OP_ROW);
	assign entry.is_last = (idx_ext == (row_len - LEN_W'(1)));
	assign entry.idx     = word_index;
	assign entry.data    = word_data;

endmodule
`default_nettype wire

// ===== sv/gmv_queue.sv =====
`default_nettype none
module gmv_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire gmv_pkg::gmv_entry_t  push_entry,
	output logic                      full,
	output logic                      pop_valid,
	input  wire logic                 pop_ready,
	output gmv_pkg::gmv_entry_t       pop_entry
);
	import gmv_pkg::*;

	gmv_entry_t        slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_pop    = pop_valid && pop_ready;
	assign pop_entry = slots_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

endmodule
`default_nettype wire

// ===== sv/gmv_back.sv =====
`default_nettype none
module gmv_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pop_valid,
	output logic                      pop_ready,
	input  wire gmv_pkg::gmv_entry_t  pop_entry,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic                      product_bit,
	output logic                      row_is_zero,
	output logic                      self_parity
);
	import gmv_pkg::*;

	logic [WORD_W-1:0] vec_mem [STORE_DEPTH];

	logic              row_s1;
	logic              last_s1;
	logic [WORD_W-1:0] data_s1;
	logic [WORD_W-1:0] vec_s1;

	logic prod_q;
	logic zero_q;
	logic par_q;
	logic out_valid_q;

	logic do_pop;
	logic s1_go;
	logic prod_nx;
	logic zero_nx;
	logic par_nx;

	// a final row word waits while the result register is held
	assign s1_go     = row_s1 && !(last_s1 && out_valid_q && result_stall);
	assign pop_ready = !row_s1 || s1_go;
	assign do_pop    = pop_valid && pop_ready;

	// vector store: loads write, row words read with a registered port
	always_ff @(posedge clk) begin
		if (do_pop && !pop_entry.is_row) vec_mem[pop_entry.idx] <= pop_entry.data;
		if (do_pop && pop_entry.is_row) begin
			vec_s1  <= vec_mem[pop_entry.idx];
			data_s1 <= pop_entry.data;
			last_s1 <= pop_entry.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_s1 <= 1'b0;
		end else if (pop_ready) begin
			row_s1 <= do_pop && pop_entry.is_row;
		end
	end

	// accumulate this word into the running row flags
	assign prod_nx = prod_q ^ (^(data_s1 & vec_s1));
	assign zero_nx = zero_q & (data_s1 == '0);
	assign par_nx  = par_q ^ (^data_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= 1'b0;
			zero_q <= 1'b1;
			par_q  <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				prod_q <= 1'b0;
				zero_q <= 1'b1;
				par_q  <= 1'b0;
			end else begin
				prod_q <= prod_nx;
				zero_q <= zero_nx;
				par_q  <= par_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			product_bit <= prod_nx;
			row_is_zero <= zero_nx;
			self_parity <= par_nx;
		end
	end

	assign result_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== sv/gf2_matrix_vector_multiply.sv =====
// GF(2) matrix-vector multiply, one 64-bit word per cycle when not stalled.
// Throughput: one word per cycle, set by the single-port vector store read.
// A row's final word passes the queue slot, the registered store read and
// the result register in that order; a held result register stalls it.
// Reset: async active-low clears queue, pipeline, accumulators and sets
// words_per_row to 1; the vector store is not cleared.
`default_nettype none
module gf2_matrix_vector_multiply (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire logic                       opcode,
	input  wire logic [gmv_pkg::IDX_W-1:0]  word_index,
	input  wire logic [gmv_pkg::WORD_W-1:0] word_data,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic                            product_bit,
	output logic                            row_is_zero,
	output logic                            self_parity,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [gmv_pkg::LEN_W-1:0]  cfg_data
);
	import gmv_pkg::*;

	logic [LEN_W-1:0] words_per_row_q;
	logic             push;
	logic             queue_full;
	logic             pop_valid;
	logic             pop_ready;
	gmv_entry_t       push_entry;
	gmv_entry_t       pop_entry;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_per_row_q <= LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			words_per_row_q <= cfg_data;
		end
	end

	gmv_front u_front (
		.item_valid    (item_valid),
		.opcode        (opcode),
		.word_index    (word_index),
		.word_data     (word_data),
		.words_per_row (words_per_row_q),
		.queue_full    (queue_full),
		.item_stall    (item_stall),
		.push          (push),
		.entry         (push_entry)
	);

	gmv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	gmv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_entry    (pop_entry),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.product_bit  (product_bit),
		.row_is_zero  (row_is_zero),
		.self_parity  (self_parity)
	);

endmodule
`default_nettype wire

// ===== sim/tb_gf2_matrix_vector_multiply.sv =====
`timescale 1ns / 100ps

module tb_gf2_matrix_vector_multiply;
	import gmv_pkg::*;

	localparam int RESET_CYCLES = 8;
	// drained queue plus the block's own pipeline before a register write
	localparam int SETTLE_CYCLES = 8;
	localparam int RAND_ITEMS = 1600;
	localparam logic [WORD_W-1:0] ONES = '1;
	localparam logic [WORD_W-1:0] TOP_BIT = {1'b1, {(WORD_W-1){1'b0}}};

	typedef struct packed {
		logic product_bit;
		logic row_is_zero;
		logic self_parity;
	} row_result_t;

	typedef enum logic {
		STIM_WORD,
		STIM_LEN
	} stim_kind_t;

	// directed table row; a length write carries its value in data
	typedef struct packed {
		stim_kind_t        kind;
		logic              op;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] data;
		logic              has_exp;
		row_result_t       exp;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              opcode = OP_LOAD;
	logic [IDX_W-1:0]  word_index = '0;
	logic [WORD_W-1:0] word_data = '0;
	logic              result_stall = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [LEN_W-1:0]  cfg_data = '0;
	wire logic         item_stall;
	wire logic         result_valid;
	wire logic         product_bit;
	wire logic         row_is_zero;
	wire logic         self_parity;
	wire logic         cfg_ready;

	// predictor state
	logic [WORD_W-1:0] vec_words [STORE_DEPTH];
	logic [LEN_W-1:0]  len_reg = LEN_W'(1);
	logic              prod_acc = 1'b0;
	logic              zero_acc = 1'b1;
	logic              par_acc = 1'b0;
	row_result_t       pending_results [$];

	int mismatches = 0;
	int items_done = 0;
	bit quiet = 1'b0;

	gf2_matrix_vector_multiply dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.word_index   (word_index),
		.word_data    (word_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.product_bit  (product_bit),
		.row_is_zero  (row_is_zero),
		.self_parity  (self_parity),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#12_000_000;
		$display("tb_gf2_matrix_vector_multiply NOT OK");
		$finish;
	end

	// row length as the block uses it: 0 counts as 1, large values saturate
	function automatic int row_len();
		int n;
		n = len_reg;
		if (n < 1) n = 1;
		if (n > LEN_LIMIT) n = LEN_LIMIT;
		return n;
	endfunction

	// one word through the inner-product predictor; returns 0 when ignored
	function automatic bit inner_product_step(input logic op, input logic [IDX_W-1:0] idx,
			input logic [WORD_W-1:0] data, output bit emits, output row_result_t res);
		int n;
		emits = 1'b0;
		res = '0;
		n = row_len();
		if (op == OP_LOAD) begin
			if (int'(idx) >= MAX_WORDS || int'(idx) >= STORE_DEPTH) return 1'b0;
			vec_words[idx] = data;
			return 1'b1;
		end
		if (int'(idx) >= n) return 1'b0;
		prod_acc ^= ^(data & vec_words[idx]);
		if (data != '0) zero_acc = 1'b0;
		par_acc ^= ^data;
		if (int'(idx) == n - 1) begin
			emits = 1'b1;
			res = {prod_acc, zero_acc, par_acc};
			prod_acc = 1'b0;
			zero_acc = 1'b1;
			par_acc = 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ONES;
			2: return TOP_BIT >> $urandom_range(0, WORD_W - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// extremes first, then mostly short rows with an occasional full or odd one
	function automatic logic [LEN_W-1:0] pick_len(input int round);
		case (round)
			0: return LEN_W'(64);
			1: return '0;
			2: return '1;
			3: return LEN_W'(1);
			default: begin
				case ($urandom_range(0, 9))
					6: return '0;
					7: return LEN_W'(64);
					8: return LEN_W'($urandom_range(65, 127));
					9: return LEN_W'($urandom_range(5, 63));
					default: return LEN_W'($urandom_range(1, 4));
				endcase
			end
		endcase
	endfunction

	// send one word, idling at random; predict once it is taken
	task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
			input logic [WORD_W-1:0] data, input logic has_exp, input row_result_t exp);
		bit emits;
		row_result_t res;
		while (!quiet && $urandom_range(0, 99) < 12) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		word_index <= idx;
		word_data <= data;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (inner_product_step(op, idx, data, emits, res)) items_done++;
		if (emits) pending_results.insert(pending_results.size(), has_exp ? exp : res);
	endtask

	task automatic wait_results_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_row_len(input logic [LEN_W-1:0] value);
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		len_reg = value;
	endtask

	// receiver: random stall, compare each taken result with the oldest prediction
	always @(posedge clk) begin : result_check
		row_result_t want;
		row_result_t got;
		result_stall <= !quiet && $urandom_range(0, 99) < 12;
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			got = {product_bit, row_is_zero, self_parity};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: product %b zero %b parity %b",
						got.product_bit, got.row_is_zero, got.self_parity);
			end else begin
				want = pending_results.pop_front();
				if (got.product_bit !== want.product_bit || got.row_is_zero !== want.row_is_zero
						|| got.self_parity !== want.self_parity) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %b/%b/%b got %b/%b/%b",
							want.product_bit, want.row_is_zero, want.self_parity,
							got.product_bit, got.row_is_zero, got.self_parity);
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t directed_rows [$];
		int len;
		int round;
		int round_items;
		int round_target;
		int pick;

		// expected results written as {product, zero, parity}
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_LOAD, 6'd0, ONES, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd0, 64'd0, 1'b1, 3'b010});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd0, ONES, 1'b1, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd0, 64'd1, 1'b1, 3'b101});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd0, TOP_BIT, 1'b1, 3'b101});
		// row word past the row end is dropped
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd63, ONES, 1'b0, 3'b000});
		// length 0 behaves as 1
		directed_rows.insert(directed_rows.size(),
			'{STIM_LEN, OP_LOAD, 6'd0, 64'd0, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd0, ONES, 1'b1, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_LOAD, 6'd1, 64'h5555_5555_5555_5555, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_LOAD, 6'd63, ONES, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_LEN, OP_LOAD, 6'd0, 64'd2, 1'b0, 3'b000});
		// last word arriving first closes the row by itself
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd1, ONES, 1'b0, 3'b000});
		// load in the middle of a row keeps the partial sums
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd0, ONES, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_LOAD, 6'd0, 64'd0, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd1, 64'd1, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd0, 64'd0, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd1, 64'd0, 1'b1, 3'b010});
		// partial row left open across a length write
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd0, 64'hF0, 1'b0, 3'b000});
		// large values saturate at the store depth
		directed_rows.insert(directed_rows.size(),
			'{STIM_LEN, OP_LOAD, 6'd0, 64'd127, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd63, 64'hFFFF_0000_0000_0001, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_LEN, OP_LOAD, 6'd0, 64'd64, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd0, ONES, 1'b0, 3'b000});
		directed_rows.insert(directed_rows.size(),
			'{STIM_WORD, OP_ROW, 6'd63, TOP_BIT, 1'b0, 3'b000});

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == STIM_LEN)
				set_row_len(directed_rows[i].data[LEN_W-1:0]);
			else
				send_word(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].data,
					directed_rows[i].has_exp, directed_rows[i].exp);
		end

		// random part: rounds of one row length each
		items_done = 0;
		for (round = 0; items_done < RAND_ITEMS; round++) begin
			set_row_len(pick_len(round));
			len = row_len();
			if (round == 0)
				for (int w = 0; w < STORE_DEPTH; w++)
					send_word(OP_LOAD, IDX_W'(w), rand_word(), 1'b0, '0);
			round_target = (len == LEN_LIMIT) ? 3 * LEN_LIMIT : 90;
			round_items = 0;
			while (round_items < round_target) begin
				quiet = items_done > 700 && items_done < 1000;
				pick = $urandom_range(0, 99);
				if (pick < 8 || (pick < 12 && len == LEN_LIMIT)) begin
					send_word(OP_LOAD, IDX_W'($urandom_range(0, STORE_DEPTH - 1)), rand_word(),
						1'b0, '0);
					round_items++;
				end else if (pick < 12) begin
					// past the row end, ignored
					send_word(OP_ROW, IDX_W'($urandom_range(len, STORE_DEPTH - 1)), rand_word(),
						1'b0, '0);
				end else if (pick < 16) begin
					// stray word out of order
					send_word(OP_ROW, IDX_W'($urandom_range(0, len - 1)), rand_word(), 1'b0, '0);
					round_items++;
				end else if (pick < 18) begin
					wait_results_drained();
				end else begin
					// complete row in order, with a rare vector load mixed in
					for (int w = 0; w < len; w++) begin
						if ($urandom_range(0, 19) == 0) begin
							send_word(OP_LOAD, IDX_W'($urandom_range(0, STORE_DEPTH - 1)),
								rand_word(), 1'b0, '0);
							round_items++;
						end
						send_word(OP_ROW, IDX_W'(w), rand_word(), 1'b0, '0);
					end
					round_items += len;
				end
			end
		end

		quiet = 1'b0;
		wait_results_drained();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_gf2_matrix_vector_multiply OK");
		else
			$display("tb_gf2_matrix_vector_multiply NOT OK");
		$finish;
	end

endmodule
